// ----- src/lwrc_pkg.sv -----
// Package for the longest word repeat counter.
// Holds mode codes, word length limits, port widths and character helpers.
// No dependencies.
`default_nettype none

package lwrc_pkg;

    // Longest word length kept in the buffers; the buffer index is 7 bits wide.
    localparam int MAX_WORD = 127;
    localparam logic [6:0] WORD_CAP = (MAX_WORD > 127) ? 7'd127 : 7'(MAX_WORD);

    // Request mode codes carried in the slave tuser.
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_END  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Stream widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // ASCII letter test.
    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Fold upper case letters to lower case; other bytes pass unchanged.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
    endfunction

    // One accepted request held in the input register.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] text_byte;
        logic [6:0] read_index;
    } t_req;

endpackage

`default_nettype wire

// ----- src/longest_word_repeat_counter.sv -----
// Top level of the longest word repeat counter.
// Depends on lwrc_pkg for mode codes, limits and character helpers.
//
// Usage:
//   Requests enter on the s_axis channel, one byte of text per request. The
//   tuser field selects the mode: a text byte, end of text, or a read of one
//   character of the stored longest word at read_index. Every request gives
//   exactly one result on the m_axis channel with the longest word length,
//   its repeat count, the word total and, for reads, the stored character.
//   An accepted request waits in the input register, where the state and the
//   word buffer are updated, and its result is then taken into the output
//   register together with the registered buffer read. Throughput is one
//   request per cycle while the receiver does not stall, set by the single
//   write and single read port of the word buffer. The case-insensitive
//   compare of a letter against the stored word completes in the cycle after
//   its buffer read and is folded into the match flag before the next word
//   close needs it.
//   When the receiver stalls, the output holds its result and the input
//   register takes one more request; s_axis_tready then drops.
//   Reset clears all counters, the match state and both valid flags; the word
//   buffer is not cleared and needs no clearing pass.
`default_nettype none

module longest_word_repeat_counter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [7:0] text_byte, [14:8] read_index, [15] zero
    input  wire logic [lwrc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: [1:0] mode
    input  wire logic [lwrc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: [6:0] longest_length, [22:7] repeat_count, [38:23] word_total,
    //        [46:39] read_char, [47] zero
    output logic [lwrc_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import lwrc_pkg::*;

    // Word buffer: two halves, one holds the longest word, the other the word
    // in progress.
    logic [7:0] mem [0:255];
    logic [7:0] r_mem_q;

    // Input register.
    t_req r_in;
    logic r_in_valid, n_in_valid;

    // Scanner state.
    logic        r_sel, n_sel;
    logic [6:0]  r_longest, n_longest;
    logic [6:0]  r_cur, n_cur;
    logic        r_in_word, n_in_word;
    logic        r_match, n_match;
    logic        r_cmp, n_cmp;
    logic [7:0]  r_cmp_c, n_cmp_c;
    logic [15:0] r_repeat, n_repeat;
    logic [15:0] r_total, n_total;

    // Output register.
    logic        r_o_valid, n_o_valid;
    logic [6:0]  r_o_len;
    logic [15:0] r_o_rep;
    logic [15:0] r_o_tot;
    logic        r_o_rd, n_o_rd;

    logic       advance, process, accept, close;
    logic       mismatch, match_eff;
    logic       wr_en, rd_en;
    logic [7:0] waddr, raddr;

    // Handshake and pipeline advance.
    assign advance       = !r_o_valid || m_axis_tready;
    assign process       = advance && r_in_valid;
    assign s_axis_tready = !r_in_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Compare result of the previous letter, available from the buffer read.
    assign mismatch  = r_cmp && (to_lower(r_mem_q) != to_lower(r_cmp_c));
    assign match_eff = r_match && !mismatch;
    assign waddr     = {~r_sel, r_cur};

    // Next state of the scanner for the request in the input register.
    always_comb begin
        n_sel     = r_sel;
        n_longest = r_longest;
        n_cur     = r_cur;
        n_in_word = r_in_word;
        n_match   = match_eff;
        n_cmp     = 1'b0;
        n_cmp_c   = r_cmp_c;
        n_repeat  = r_repeat;
        n_total   = r_total;
        n_o_rd    = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        raddr     = {r_sel, r_in.read_index};
        close     = 1'b0;

        if (process) begin
            unique case (r_in.mode)
                MODE_TEXT: begin
                    if (is_letter(r_in.text_byte)) begin
                        n_in_word = 1'b1;
                        if (r_cur < WORD_CAP) begin
                            wr_en = 1'b1;
                            n_cur = r_cur + 7'd1;
                            if (r_cur < r_longest) begin
                                n_cmp   = 1'b1;
                                n_cmp_c = r_in.text_byte;
                                rd_en   = 1'b1;
                                raddr   = {r_sel, r_cur};
                            end
                        end
                    end else begin
                        close = 1'b1;
                    end
                end
                MODE_END: begin
                    close = 1'b1;
                end
                MODE_READ: begin
                    n_o_rd = r_in.read_index < r_longest;
                    rd_en  = n_o_rd;
                end
                default: begin
                end
            endcase
        end

        // Word close: count it, then compare against the stored longest word.
        if (close && r_in_word) begin
            if (r_total != 16'hFFFF) begin
                n_total = r_total + 16'd1;
            end
            if (r_cur > r_longest) begin
                n_sel     = ~r_sel;
                n_longest = r_cur;
                n_repeat  = 16'd1;
            end else if ((r_cur == r_longest) && match_eff && (r_repeat != 16'hFFFF)) begin
                n_repeat = r_repeat + 16'd1;
            end
            n_in_word = 1'b0;
            n_cur     = 7'd0;
            n_match   = 1'b1;
        end
    end

    // Valid flags.
    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (process) begin
            n_in_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (process) begin
            n_o_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_o_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_sel      <= 1'b0;
            r_longest  <= 7'd0;
            r_cur      <= 7'd0;
            r_in_word  <= 1'b0;
            r_match    <= 1'b1;
            r_cmp      <= 1'b0;
            r_repeat   <= 16'd0;
            r_total    <= 16'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_o_valid  <= n_o_valid;
            r_sel      <= n_sel;
            r_longest  <= n_longest;
            r_cur      <= n_cur;
            r_in_word  <= n_in_word;
            r_match    <= n_match;
            r_cmp      <= n_cmp;
            r_repeat   <= n_repeat;
            r_total    <= n_total;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmp_c <= n_cmp_c;
        if (accept) begin
            r_in.mode       <= s_axis_tuser;
            r_in.text_byte  <= s_axis_tdata[7:0];
            r_in.read_index <= s_axis_tdata[14:8];
        end
        if (process) begin
            r_o_len <= n_longest;
            r_o_rep <= n_repeat;
            r_o_tot <= n_total;
            r_o_rd  <= n_o_rd;
        end
    end

    // Word buffer with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= r_in.text_byte;
        end
        if (rd_en) begin
            r_mem_q <= mem[raddr];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, (r_o_rd ? r_mem_q : 8'd0), r_o_tot, r_o_rep, r_o_len};

endmodule

`default_nettype wire

// ----- src/lwrc_checker.sv -----
// Port-level checker for the longest word repeat counter, with its bind.
// Depends on lwrc_pkg for stream widths.
`default_nettype none

module lwrc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [lwrc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import lwrc_pkg::*;

    logic [6:0]  len;
    logic [15:0] rep;
    logic [15:0] tot;
    logic [7:0]  rch;

    assign len = m_axis_tdata[6:0];
    assign rep = m_axis_tdata[22:7];
    assign tot = m_axis_tdata[38:23];
    assign rch = m_axis_tdata[46:39];

    // A stalled result stays valid.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A longest word exists exactly when it has been seen at least once,
    // and it cannot repeat more often than words were closed.
    a_repeat_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (((rep == 16'd0) == (len == 7'd0)) && (rep <= tot)))
        else $error("repeat count inconsistent with length or total");

    // A returned character is part of a stored word, so it is a letter.
    a_read_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (rch != 8'd0) |-> is_letter(rch) && (len != 7'd0))
        else $error("read character is not a stored letter");

endmodule

bind longest_word_repeat_counter lwrc_checker u_lwrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
